### design/osnl_pkg.sv
// Shared types, constants and helpers for the octree sphere node locate unit.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package osnl_pkg;

  // Field widths fixed by the interface.
  localparam int CoordBits  = 32;
  localparam int RadBits    = 31;
  localparam int DepthBits  = 4;
  localparam int PathBits   = 24;
  localparam int CfgBits    = 32;
  localparam int RegIdxBits = 3;

  // Internal arithmetic widths. A difference of two coordinates needs one extra bit; deltas carry two.
  localparam int DeltaBits = CoordBits + 2;
  localparam int SqBits    = 2 * RadBits;
  localparam int SumBits   = SqBits + 2;

  // Default deepest subdivision level and the register stages ahead of the level chain.
  localparam int MaxDepth    = 8;
  localparam int FrontStages = 5;

  // Configuration register indexes.
  localparam logic [RegIdxBits-1:0] RegCenterX   = 3'd0;
  localparam logic [RegIdxBits-1:0] RegCenterY   = 3'd1;
  localparam logic [RegIdxBits-1:0] RegCenterZ   = 3'd2;
  localparam logic [RegIdxBits-1:0] RegHalfWidth = 3'd3;
  localparam logic [RegIdxBits-1:0] RegDepth     = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [RadBits-1:0]   HalfWidthReset = 31'd65536;
  localparam logic [DepthBits-1:0] DepthReset     = 4'd3;

  // One sphere request.
  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] point_z;
    logic [RadBits-1:0]          radius;
  } req_t;

  // One placement result.
  typedef struct packed {
    logic                 placed;
    logic [DepthBits-1:0] level;
    logic [PathBits-1:0]  octant_path;
    logic                 root_partial;
  } res_t;

  // Root cube and effective depth limit, already clamped to the pipeline depth.
  typedef struct packed {
    logic signed [CoordBits-1:0] center_x;
    logic signed [CoordBits-1:0] center_y;
    logic signed [CoordBits-1:0] center_z;
    logic [RadBits-1:0]          half_width;
    logic [DepthBits-1:0]        depth_limit;
  } cfg_t;

  // State of one request as it walks down the level stages.
  // The deltas hold sphere centre minus current node centre.
  typedef struct packed {
    logic                        valid;
    logic                        go;
    logic                        root_hold;
    logic                        touch;
    logic signed [DeltaBits-1:0] dx;
    logic signed [DeltaBits-1:0] dy;
    logic signed [DeltaBits-1:0] dz;
    logic [RadBits-1:0]          radius;
    logic [DepthBits-1:0]        level;
    logic [PathBits-1:0]         path;
  } lvl_t;

  // Sign-extend a coordinate to the delta width.
  function automatic logic signed [DeltaBits-1:0] sext_coord(input logic [CoordBits-1:0] v);
    return $signed({{(DeltaBits - CoordBits){v[CoordBits-1]}}, v});
  endfunction

  // Zero-extend an unsigned magnitude to the delta width as a signed value.
  function automatic logic signed [DeltaBits-1:0] zext_mag(input logic [RadBits-1:0] v);
    return $signed({{(DeltaBits - RadBits){1'b0}}, v});
  endfunction

endpackage

### design/octree_sphere_node_locate_unit.sv
// Top level of the octree sphere node locate unit: configuration registers and pipeline.
// Depends on osnl_pkg, osnl_front and osnl_level.
`timescale 1ns / 1ps

// A new sphere request is taken in every clock cycle; busy is high only while
// rst is asserted. Each result leaves on done in request order and with no gaps
// added, after five front stages (centre deltas, root containment, squared
// distances, their sum, the overlap compare), one stage per octree level, and
// the output register. The receiver cannot stall the unit, so done must be
// sampled in the cycle it is high. Write the root cube and depth limit only
// while no request is in flight.
module octree_sphere_node_locate_unit #(
  parameter int MAX_DEPTH = osnl_pkg::MaxDepth
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  osnl_pkg::req_t                      req,
  output logic                                done,
  output osnl_pkg::res_t                      result,
  input  logic                                cfg_wr_en,
  input  logic [osnl_pkg::RegIdxBits-1:0]     cfg_index,
  input  logic [osnl_pkg::CfgBits-1:0]        cfg_data
);

  localparam int DB      = osnl_pkg::DepthBits;
  localparam int Latency = osnl_pkg::FrontStages + MAX_DEPTH + 1;

  // Configuration registers.
  logic signed [osnl_pkg::CoordBits-1:0] center_x;
  logic signed [osnl_pkg::CoordBits-1:0] center_y;
  logic signed [osnl_pkg::CoordBits-1:0] center_z;
  logic [osnl_pkg::RadBits-1:0]          half_width;
  logic [DB-1:0]                         depth_limit;

  osnl_pkg::cfg_t cfg;
  osnl_pkg::lvl_t chain [MAX_DEPTH+1];
  osnl_pkg::res_t result_next;
  logic           accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      center_z    <= '0;
      half_width  <= osnl_pkg::HalfWidthReset;
      depth_limit <= osnl_pkg::DepthReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        osnl_pkg::RegCenterX:   center_x    <= cfg_data;
        osnl_pkg::RegCenterY:   center_y    <= cfg_data;
        osnl_pkg::RegCenterZ:   center_z    <= cfg_data;
        osnl_pkg::RegHalfWidth: half_width  <= cfg_data[osnl_pkg::RadBits-1:0];
        osnl_pkg::RegDepth:     depth_limit <= cfg_data[DB-1:0];
        default: ;
      endcase
    end
  end

  // Root cube and the depth limit clamped to the levels built in.
  always_comb begin
    cfg.center_x    = center_x;
    cfg.center_y    = center_y;
    cfg.center_z    = center_z;
    cfg.half_width  = half_width;
    cfg.depth_limit = (depth_limit > DB'(MAX_DEPTH)) ? DB'(MAX_DEPTH) : depth_limit;
  end

  osnl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .valid (accept),
    .req   (req),
    .stage (chain[0])
  );

  // One stage per subdivision level.
  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_level
    osnl_level #(
      .LEVEL (g)
    ) u_level (
      .clk   (clk),
      .rst   (rst),
      .cfg   (cfg),
      .prev  (chain[g]),
      .stage (chain[g+1])
    );
  end

  // Final placement: contained spheres keep their node, overlapping ones stay at the root.
  always_comb begin
    result_next.placed       = chain[MAX_DEPTH].root_hold || chain[MAX_DEPTH].touch;
    result_next.root_partial = !chain[MAX_DEPTH].root_hold && chain[MAX_DEPTH].touch;
    result_next.level        = chain[MAX_DEPTH].root_hold ? chain[MAX_DEPTH].level : '0;
    result_next.octant_path  = chain[MAX_DEPTH].root_hold ? chain[MAX_DEPTH].path : '0;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[MAX_DEPTH].valid;
    end
  end

`ifndef SYNTHESIS
  // Every request taken comes out after the fixed latency.
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##Latency done)
    else $error("request did not produce a result after the pipeline latency");

  // Every result traces back to a request taken at the fixed latency.
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, Latency))
    else $error("result without a matching request");

  // A sphere kept at the root by overlap has no path below the root.
  a_partial_root: assert property (@(posedge clk) disable iff (rst)
    (done && result.root_partial) |->
      (result.placed && (result.level == '0) && (result.octant_path == '0)))
    else $error("partial overlap result is not a plain root placement");

  // The chosen node never lies below the configured depth.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.level <= cfg.depth_limit))
    else $error("result level exceeds the depth limit");
`endif

endmodule

### design/osnl_front.sv
// Front stages: root containment test and the partial-overlap distance check.
// Depends on osnl_pkg; feeds the first level stage.
`timescale 1ns / 1ps

module osnl_front (
  input  logic              clk,
  input  logic              rst,
  input  osnl_pkg::cfg_t    cfg,
  input  logic              valid,
  input  osnl_pkg::req_t    req,
  output osnl_pkg::lvl_t    stage
);

  localparam int DW = osnl_pkg::DeltaBits;
  localparam int RW = osnl_pkg::RadBits;
  localparam int QW = osnl_pkg::SqBits;
  localparam int SW = osnl_pkg::SumBits;

  // Stage 1 registers.
  logic                 s1_valid;
  logic signed [DW-1:0] s1_dp [3];
  logic signed [DW-1:0] s1_dn [3];
  logic signed [DW-1:0] s1_lim;
  logic signed [DW-1:0] s1_limn;
  logic [RW-1:0]        s1_r;

  // Stage 2 registers.
  logic                 s2_valid;
  logic                 s2_hold;
  logic signed [DW-1:0] s2_dp [3];
  logic signed [DW-1:0] s2_ex [3];
  logic [RW-1:0]        s2_r;

  // Stage 3 registers.
  logic                 s3_valid;
  logic                 s3_hold;
  logic                 s3_far;
  logic signed [DW-1:0] s3_dp [3];
  logic [QW-1:0]        s3_sq [3];
  logic [QW-1:0]        s3_r2;
  logic [RW-1:0]        s3_r;

  // Stage 4 registers.
  logic                 s4_valid;
  logic                 s4_hold;
  logic                 s4_far;
  logic signed [DW-1:0] s4_dp [3];
  logic [SW-1:0]        s4_sum;
  logic [QW-1:0]        s4_r2;
  logic [RW-1:0]        s4_r;

  // Combinational values between the stages.
  logic signed [DW-1:0] pe [3];
  logic signed [DW-1:0] ce [3];
  logic signed [DW-1:0] hw_e;
  logic signed [DW-1:0] r_in;
  logic signed [DW-1:0] r_s2;
  logic [2:0]           in_box;
  logic [2:0]           beyond;
  logic [RW-1:0]        dc [3];
  osnl_pkg::lvl_t       stage_next;

  always_comb begin
    pe[0] = osnl_pkg::sext_coord(req.point_x);
    pe[1] = osnl_pkg::sext_coord(req.point_y);
    pe[2] = osnl_pkg::sext_coord(req.point_z);
    ce[0] = osnl_pkg::sext_coord(cfg.center_x);
    ce[1] = osnl_pkg::sext_coord(cfg.center_y);
    ce[2] = osnl_pkg::sext_coord(cfg.center_z);
    hw_e  = osnl_pkg::zext_mag(cfg.half_width);
    r_in  = osnl_pkg::zext_mag(req.radius);
    r_s2  = osnl_pkg::zext_mag(s2_r);
    for (int i = 0; i < 3; i++) begin
      // The root holds the sphere when |delta| <= h - r on every axis.
      in_box[i] = (s1_dp[i] <= s1_lim) && (s1_dp[i] >= s1_limn);
      // Distance past the face; a negative value means inside on that axis.
      beyond[i] = (s2_ex[i] > r_s2);
      dc[i]     = s2_ex[i][DW-1] ? '0 : s2_ex[i][RW-1:0];
    end
  end

  // Stage 1: centre deltas in both signs and the root containment bound.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_dp[i] <= pe[i] - ce[i];
      s1_dn[i] <= ce[i] - pe[i];
    end
    s1_lim  <= hw_e - r_in;
    s1_limn <= r_in - hw_e;
    s1_r    <= req.radius;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= valid;
    end
  end

  // Stage 2: root containment and per-axis distance outside the root cube.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_dp[i] <= s1_dp[i];
      s2_ex[i] <= (s1_dp[i][DW-1] ? s1_dn[i] : s1_dp[i]) - hw_e;
    end
    s2_hold <= &in_box;
    s2_r    <= s1_r;
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // Stage 3: squares of the clamped distances and of the radius.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_dp[i] <= s2_dp[i];
      s3_sq[i] <= QW'(dc[i]) * QW'(dc[i]);
    end
    s3_r2   <= QW'(s2_r) * QW'(s2_r);
    s3_far  <= |beyond;
    s3_hold <= s2_hold;
    s3_r    <= s2_r;
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  // Stage 4: squared distance from the root cube.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_dp[i] <= s3_dp[i];
    end
    s4_sum  <= SW'(s3_sq[0]) + SW'(s3_sq[1]) + SW'(s3_sq[2]);
    s4_r2   <= s3_r2;
    s4_far  <= s3_far;
    s4_hold <= s3_hold;
    s4_r    <= s3_r;
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  // Stage 5: overlap decision and hand-off to the level chain at the root.
  always_comb begin
    stage_next.valid     = s4_valid;
    stage_next.go        = s4_hold;
    stage_next.root_hold = s4_hold;
    stage_next.touch     = !s4_far && (s4_r != '0) && (s4_sum <= SW'(s4_r2));
    stage_next.dx        = s4_dp[0];
    stage_next.dy        = s4_dp[1];
    stage_next.dz        = s4_dp[2];
    stage_next.radius    = s4_r;
    stage_next.level     = '0;
    stage_next.path      = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

endmodule

### design/osnl_level.sv
// One octree level stage: picks the child octant and tests whether it holds the sphere.
// Depends on osnl_pkg; instantiated once per level by the top level.
`timescale 1ns / 1ps

module osnl_level #(
  parameter int LEVEL = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  osnl_pkg::cfg_t cfg,
  input  osnl_pkg::lvl_t prev,
  output osnl_pkg::lvl_t stage
);

  localparam int DW = osnl_pkg::DeltaBits;
  localparam int PW = osnl_pkg::PathBits;
  localparam int DB = osnl_pkg::DepthBits;

  logic signed [DW-1:0] ch;
  logic signed [DW-1:0] lim;
  logic signed [DW-1:0] d_in [3];
  logic signed [DW-1:0] d_nx [3];
  logic [2:0]           oct;
  logic [2:0]           ok;
  logic                 descend;
  logic [PW+2:0]        path_ext;
  osnl_pkg::lvl_t       stage_next;

  always_comb begin
    // Child half width and the bound |delta| must stay within.
    ch  = $signed(DW'(cfg.half_width >> (LEVEL + 1)));
    lim = ch - osnl_pkg::zext_mag(prev.radius);

    d_in[0] = prev.dx;
    d_in[1] = prev.dy;
    d_in[2] = prev.dz;

    // Octant bit is set when the node centre is at or below the sphere centre;
    // the child centre then moves up by the child half width.
    for (int i = 0; i < 3; i++) begin
      oct[i]  = ~d_in[i][DW-1];
      d_nx[i] = oct[i] ? (d_in[i] - ch) : (d_in[i] + ch);
      ok[i]   = (d_nx[i] <= lim) && (d_nx[i] >= -lim);
    end

    descend  = prev.go && (DB'(LEVEL) < cfg.depth_limit) && (&ok);
    path_ext = {3'b000, prev.path} | ({PW'(0), oct} << (3 * LEVEL));

    stage_next    = prev;
    stage_next.go = descend;
    if (descend) begin
      stage_next.dx    = d_nx[0];
      stage_next.dy    = d_nx[1];
      stage_next.dz    = d_nx[2];
      stage_next.level = prev.level + DB'(1);
      stage_next.path  = path_ext[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

endmodule
